[rtl/fjot_pkg.sv]
// Package for the flat JSON object tokenizer: phase codes, event kinds,
// character constants and the state and result structs.
// No dependencies.
package fjot_pkg;

  // Expected-token phase codes.
  localparam logic [3:0] PH_BRACE       = 4'd0;
  localparam logic [3:0] PH_KEY_QUOTE   = 4'd1;
  localparam logic [3:0] PH_KEY         = 4'd2;
  localparam logic [3:0] PH_COLON       = 4'd3;
  localparam logic [3:0] PH_VALUE_QUOTE = 4'd4;
  localparam logic [3:0] PH_VALUE       = 4'd5;
  localparam logic [3:0] PH_COMMA       = 4'd6;
  localparam logic [3:0] PH_DONE        = 4'd7;
  localparam logic [3:0] PH_FAILED      = 4'd8;

  // Result event kinds.
  localparam logic [2:0] EV_KEY_BYTE   = 3'd0;
  localparam logic [2:0] EV_KEY_END    = 3'd1;
  localparam logic [2:0] EV_VALUE_BYTE = 3'd2;
  localparam logic [2:0] EV_PAIR_END   = 3'd3;
  localparam logic [2:0] EV_CLOSED     = 3'd4;
  localparam logic [2:0] EV_FAILED     = 3'd5;

  // Input function codes.
  localparam logic FN_BYTE = 1'b0;
  localparam logic FN_END  = 1'b1;

  // Characters the tokenizer looks for.
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;

  // Tokenizer state carried from item to item.
  typedef struct packed {
    logic [3:0] phase;
    logic [7:0] prev_byte;
    logic       skip_space;
    logic       fail_sent;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_BRACE,
    prev_byte:  8'h00,
    skip_space: 1'b1,
    fail_sent:  1'b0
  };

  // Result of one step: at most one event.
  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic [7:0] data;
  } result_t;

endpackage

[rtl/fjot_if.sv]
// Valid/ready channel interfaces for the tokenizer: the input byte channel
// and the event channel. No dependencies.
interface fjot_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;

  modport source (output valid, output func, output in_byte, input ready);
  modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface fjot_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] out_byte;

  modport source (output valid, output event_kind, output out_byte, input ready);
  modport sink   (input valid, input event_kind, input out_byte, output ready);
endinterface

[rtl/fjot_decode.sv]
// One tokenizer step: from the current state and one input item, the next
// state and the event it causes. Depends on fjot_pkg.
module fjot_decode (
  input  fjot_pkg::state_t  state,
  input  logic              func,
  input  logic [7:0]        in_byte,
  output fjot_pkg::state_t  state_nxt,
  output fjot_pkg::result_t result
);
  import fjot_pkg::*;

  logic is_space;
  logic is_close_quote;

  // Whitespace and unescaped closing quote detection.
  assign is_space = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                    (in_byte == CH_CR) || (in_byte == CH_LF);
  assign is_close_quote = (in_byte == CH_QUOTE) && (state.prev_byte != CH_BACKSLASH);

  // Phase decode for one item.
  always_comb begin
    state_nxt = state;
    result    = '{emit: 1'b0, kind: EV_KEY_BYTE, data: 8'h00};
    if (func == FN_END) begin
      // End of text gives the verdict for an unfinished object, then resets.
      result.emit = (state.phase != PH_DONE) && !state.fail_sent;
      result.kind = EV_FAILED;
      state_nxt   = STATE_RESET;
    end else begin
      state_nxt.prev_byte = in_byte;
      if (state.phase >= PH_DONE) begin
        // Closed or failed: bytes are ignored.
      end else if (state.skip_space && is_space) begin
        // Whitespace between tokens is dropped.
      end else begin
        state_nxt.skip_space = 1'b0;
        unique case (state.phase)
          PH_BRACE: begin
            if (in_byte == CH_LBRACE) begin
              state_nxt.phase      = PH_KEY_QUOTE;
              state_nxt.skip_space = 1'b1;
            end else begin
              state_nxt.phase     = PH_FAILED;
              state_nxt.fail_sent = 1'b1;
              result.emit         = 1'b1;
              result.kind         = EV_FAILED;
            end
          end
          PH_KEY_QUOTE: begin
            if (in_byte == CH_QUOTE) begin
              state_nxt.phase = PH_KEY;
            end else begin
              state_nxt.phase     = PH_FAILED;
              state_nxt.fail_sent = 1'b1;
              result.emit         = 1'b1;
              result.kind         = EV_FAILED;
            end
          end
          PH_KEY: begin
            result.emit = 1'b1;
            if (is_close_quote) begin
              state_nxt.phase      = PH_COLON;
              state_nxt.skip_space = 1'b1;
              result.kind          = EV_KEY_END;
            end else begin
              result.kind = EV_KEY_BYTE;
              result.data = in_byte;
            end
          end
          PH_COLON: begin
            if (in_byte == CH_COLON) begin
              state_nxt.phase      = PH_VALUE_QUOTE;
              state_nxt.skip_space = 1'b1;
            end else begin
              state_nxt.phase     = PH_FAILED;
              state_nxt.fail_sent = 1'b1;
              result.emit         = 1'b1;
              result.kind         = EV_FAILED;
            end
          end
          PH_VALUE_QUOTE: begin
            if (in_byte == CH_QUOTE) begin
              state_nxt.phase = PH_VALUE;
            end else begin
              state_nxt.phase     = PH_FAILED;
              state_nxt.fail_sent = 1'b1;
              result.emit         = 1'b1;
              result.kind         = EV_FAILED;
            end
          end
          PH_VALUE: begin
            result.emit = 1'b1;
            if (is_close_quote) begin
              state_nxt.phase      = PH_COMMA;
              state_nxt.skip_space = 1'b1;
              result.kind          = EV_PAIR_END;
            end else begin
              result.kind = EV_VALUE_BYTE;
              result.data = in_byte;
            end
          end
          PH_COMMA: begin
            result.emit = 1'b1;
            if (in_byte == CH_COMMA) begin
              state_nxt.phase      = PH_KEY_QUOTE;
              state_nxt.skip_space = 1'b1;
              result.emit          = 1'b0;
            end else if (in_byte == CH_RBRACE) begin
              state_nxt.phase = PH_DONE;
              result.kind     = EV_CLOSED;
            end else begin
              state_nxt.phase     = PH_FAILED;
              state_nxt.fail_sent = 1'b1;
              result.kind         = EV_FAILED;
            end
          end
          default: begin
            // Codes at or above done are handled above.
          end
        endcase
      end
    end
  end

endmodule

[rtl/flat_json_object_tokenizer_unit.sv]
// Top level of the flat JSON object tokenizer: input register, step decode
// and event register. Depends on fjot_pkg, fjot_if and fjot_decode.
//
// The tokenizer takes one item per clock while the event channel does not
// stall: a text byte or an end-of-text marker. Each item passes an input
// register, then one step of phase decode that updates the tokenizer state
// and loads the event register, which offers the event. The input side
// keeps accepting while an event waits to be taken; a stall on the event
// channel holds back the input only once both registers are full. Items
// that cause no event (whitespace, punctuation, ignored bytes) still take
// one slot each. Key and value bytes are passed out as they arrive, escapes
// untouched, each string followed by its end event; a syntax error or early
// end gives a single failure event.
module flat_json_object_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  fjot_in_if.sink     in_chan,
  fjot_out_if.source  out_chan
);
  import fjot_pkg::*;

  logic       in_valid_r;
  logic       in_func_r;
  logic [7:0] in_byte_r;
  logic       step_fire;

  state_t     state_r;
  state_t     state_nxt;
  result_t    step_res;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [2:0] out_kind_r;
  logic [7:0] out_byte_r;

  // The decode stage advances when the event register is free or draining.
  assign step_fire     = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || step_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_func_r <= in_chan.func;
      in_byte_r <= in_chan.in_byte;
    end
  end

  // One tokenizer step on the registered item.
  fjot_decode u_decode (
    .state     (state_r),
    .func      (in_func_r),
    .in_byte   (in_byte_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // Tokenizer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (step_fire) begin
      state_r <= state_nxt;
    end
  end

  // Event register.
  always_comb begin
    if (step_fire) begin
      out_valid_nxt = step_res.emit;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && step_res.emit) begin
      out_kind_r <= step_res.kind;
      out_byte_r <= step_res.data;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.event_kind = out_kind_r;
  assign out_chan.out_byte   = out_byte_r;

`ifndef SYNTHESIS
  // The failed phase is only entered together with the failure flag.
  a_failed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_FAILED) |-> state_r.fail_sent)
    else $error("failed phase without failure flag");

  // A closed object never follows a reported failure.
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_DONE) |-> !state_r.fail_sent)
    else $error("object closed after a failure");

  // Inside a key or a value, whitespace skipping is always off.
  a_key_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r.phase == PH_KEY) || (state_r.phase == PH_VALUE)) |-> !state_r.skip_space)
    else $error("whitespace skip active inside a string");

  // A valid event carries a defined kind.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r <= EV_FAILED))
    else $error("event kind out of range");
`endif

endmodule

[dv/flat_json_object_tokenizer_unit_test.sv]
// Testbench for flat_json_object_tokenizer_unit: drives text bytes and end-of-text
// items, predicts the key/value event stream and checks every event in order.
// Depends on fjot_pkg, fjot_if and the tokenizer RTL.
module flat_json_object_tokenizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fjot_pkg::*;

  localparam int TEXT_ITEMS = 1450;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } text_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } token_event_t;

  logic clk;
  logic rst_n;

  fjot_in_if  in_chan ();
  fjot_out_if out_chan ();

  flat_json_object_tokenizer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Text waiting to be sent, and events predicted but not yet seen.
  text_item_t   text_q[$];
  token_event_t token_q[$];

  // Predicted tokenizer state.
  logic [3:0] tk_phase;
  logic [7:0] tk_prev;
  logic       tk_skip;
  logic       tk_fail_sent;

  int  fail_count = 0;
  int  idle_cycles = 0;
  int  in_gap = 0;
  int  out_stall = 0;
  bit  calm = 0;
  bit  in_fire = 0;
  bit  out_fire = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  // Idle length: mostly none or short, sometimes long, none at all in calm stretches.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 199) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Printable byte other than quote and backslash.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = rand_byte() % 8'd95 + 8'h20;
    end while (c == CH_QUOTE || c == CH_BACKSLASH);
    return c;
  endfunction

  function automatic void add_event(logic [2:0] kind, logic [7:0] data);
    token_event_t ev;
    ev.kind = kind;
    ev.data = data;
    token_q.push_back(ev);
  endfunction

  function automatic void report_failure();
    tk_phase = PH_FAILED;
    tk_fail_sent = 1'b1;
    add_event(EV_FAILED, 8'h00);
  endfunction

  function automatic void clear_tokenizer();
    tk_phase = PH_BRACE;
    tk_prev = 8'h00;
    tk_skip = 1'b1;
    tk_fail_sent = 1'b0;
  endfunction

  // Advance the predicted tokenizer by one accepted item.
  function automatic void tokenize_step(logic fn, logic [7:0] b);
    logic [7:0] prior;
    if (fn == FN_END) begin
      if (tk_phase != PH_DONE && !tk_fail_sent) add_event(EV_FAILED, 8'h00);
      clear_tokenizer();
      return;
    end
    prior = tk_prev;
    tk_prev = b;
    if (tk_phase >= PH_DONE) return;
    if (tk_skip) begin
      if (b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) return;
      tk_skip = 1'b0;
    end
    case (tk_phase)
      PH_BRACE: begin
        if (b != CH_LBRACE) report_failure();
        else begin
          tk_phase = PH_KEY_QUOTE;
          tk_skip = 1'b1;
        end
      end
      PH_KEY_QUOTE: begin
        if (b != CH_QUOTE) report_failure();
        else tk_phase = PH_KEY;
      end
      PH_KEY: begin
        if (b == CH_QUOTE && prior != CH_BACKSLASH) begin
          tk_phase = PH_COLON;
          tk_skip = 1'b1;
          add_event(EV_KEY_END, 8'h00);
        end else begin
          add_event(EV_KEY_BYTE, b);
        end
      end
      PH_COLON: begin
        if (b != CH_COLON) report_failure();
        else begin
          tk_phase = PH_VALUE_QUOTE;
          tk_skip = 1'b1;
        end
      end
      PH_VALUE_QUOTE: begin
        if (b != CH_QUOTE) report_failure();
        else tk_phase = PH_VALUE;
      end
      PH_VALUE: begin
        if (b == CH_QUOTE && prior != CH_BACKSLASH) begin
          tk_phase = PH_COMMA;
          tk_skip = 1'b1;
          add_event(EV_PAIR_END, 8'h00);
        end else begin
          add_event(EV_VALUE_BYTE, b);
        end
      end
      PH_COMMA: begin
        if (b == CH_COMMA) begin
          tk_phase = PH_KEY_QUOTE;
          tk_skip = 1'b1;
        end else if (b == CH_RBRACE) begin
          tk_phase = PH_DONE;
          add_event(EV_CLOSED, 8'h00);
        end else begin
          report_failure();
        end
      end
      default: ;
    endcase
  endfunction

  // Stimulus building.
  function automatic void push_byte(logic [7:0] b);
    text_item_t it;
    it.func = FN_BYTE;
    it.data = b;
    text_q.push_back(it);
  endfunction

  function automatic void push_end();
    text_item_t it;
    it.func = FN_END;
    it.data = rand_byte();
    text_q.push_back(it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void pad_blank(ref logic [7:0] text[$], input int most);
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, most) : 0;
    for (int i = 0; i < n; i++) text.push_back(blank_char());
  endfunction

  // String body without an unescaped quote; never ends in a lone backslash.
  function automatic void fill_string(ref logic [7:0] text[$], input int n);
    int r;
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        text.push_back(plain_char());
      end else if (r == 7) begin
        text.push_back(blank_char());
      end else if (r == 8) begin
        text.push_back(CH_BACKSLASH);
        text.push_back(($urandom_range(0, 1) == 0) ? CH_QUOTE : plain_char());
      end else begin
        do begin
          c = rand_byte();
        end while (c == CH_QUOTE || c == CH_BACKSLASH);
        text.push_back(c);
      end
    end
  endfunction

  // One object: mostly well formed, some corrupted or cut short, some pure noise.
  function automatic void push_object();
    logic [7:0] text[$];
    int mode;
    int pairs;
    int cut;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      for (int i = 0; i < $urandom_range(1, 6); i++) text.push_back(rand_byte());
    end else begin
      pad_blank(text, 3);
      text.push_back(CH_LBRACE);
      pad_blank(text, 2);
      pairs = $urandom_range(1, 4);
      for (int p = 0; p < pairs; p++) begin
        text.push_back(CH_QUOTE);
        fill_string(text, $urandom_range(0, 5));
        text.push_back(CH_QUOTE);
        pad_blank(text, 2);
        text.push_back(CH_COLON);
        pad_blank(text, 2);
        text.push_back(CH_QUOTE);
        fill_string(text, $urandom_range(0, 6));
        text.push_back(CH_QUOTE);
        pad_blank(text, 2);
        if (p != pairs - 1) begin
          text.push_back(CH_COMMA);
          pad_blank(text, 2);
        end
      end
      text.push_back(CH_RBRACE);
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < $urandom_range(1, 4); i++) text.push_back(rand_byte());
      end
      if (mode < 23) begin
        text[$urandom_range(0, text.size() - 1)] = rand_byte();
      end else if (mode < 33) begin
        cut = $urandom_range(0, text.size() - 1);
        while (text.size() > cut) void'(text.pop_back());
      end
    end
    foreach (text[i]) push_byte(text[i]);
    push_end();
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.func = FN_BYTE;
    in_chan.in_byte = 8'h00;
    out_chan.ready = 1'b0;
    clear_tokenizer();

    // Empty text ends early.
    push_end();
    // Leading and inner whitespace, extreme bytes in a key, an escaped quote,
    // whitespace kept inside a value, and a byte after the closing brace.
    push_text(" \t\r\n{ \"");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("\\\"\" :\n\"\t x\"}");
    push_byte(8'hFF);
    push_end();
    // Wrong first byte, then bytes ignored until end of text.
    push_text("x{");
    push_end();
    // Text that ends in whitespace.
    push_text("{ ");
    push_end();

    while (text_q.size() < TEXT_ITEMS) push_object();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_chan.valid || token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Input driver: a new item once the current one is taken and any gap has run out.
  always @(negedge clk) begin : in_driver
    text_item_t it;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_chan.valid <= 1'b0;
      end else if (text_q.size() != 0) begin
        it = text_q.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.func <= it.func;
        in_chan.in_byte <= it.data;
        in_gap = pick_gap();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Event receiver stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
      out_stall = pick_gap();
    end
  end

  // Monitor: predict on each accepted item, check each accepted event.
  always @(posedge clk) begin : monitor
    token_event_t want;
    if (rst_n) begin
      in_fire = in_chan.valid && in_chan.ready;
      out_fire = out_chan.valid && out_chan.ready;
      if (out_fire) begin
        if (token_q.size() == 0) begin
          $error("unexpected event: event_kind %0d, out_byte 0x%02h",
                 out_chan.event_kind, out_chan.out_byte);
          fail_count++;
        end else begin
          want = token_q.pop_front();
          if (out_chan.event_kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, out_chan.event_kind);
            fail_count++;
          end
          if (out_chan.out_byte !== want.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, out_chan.out_byte);
            fail_count++;
          end
        end
      end
      if (in_fire) tokenize_step(in_chan.func, in_chan.in_byte);

      // Watchdog on cycles where neither side moves an item.
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
rtl/fjot_pkg.sv
rtl/fjot_if.sv
rtl/fjot_decode.sv
rtl/flat_json_object_tokenizer_unit.sv
dv/flat_json_object_tokenizer_unit_test.sv
